### rtl/core/tps_pkg.sv
// Shared widths, codes and record types of the triangle plane split unit.
`default_nettype none

package tps_pkg;

    // Coordinate width; values above 32 bits are treated as 32
    localparam int COORD_BITS = 32;
    localparam int CW = (COORD_BITS > 32) ? 32 : ((COORD_BITS < 16) ? 16 : COORD_BITS);
    localparam int OW = 32;             // width of a coordinate field on the ports
    localparam int DW = CW + 1;         // signed distance to the plane
    localparam int EW = CW + 2;         // distance difference along an edge
    localparam int T_FRAC = 30;         // fraction bits of the edge parameter
    localparam int TW = T_FRAC + 1;     // edge parameter including the value one
    localparam int T_LO_W = 15;         // low slice of the parameter per product
    localparam int T_HI_W = TW - T_LO_W;
    localparam int PW = DW + TW + 2;    // full product plus rounding
    localparam int EPS_Q = 7;           // on-plane and near-parallel tolerance
    localparam int DIV_STAGES = T_FRAC; // one quotient bit per stage

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SPLIT_AXIS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SPLIT_VALUE = 1'b1;

    // Axis codes; the unused codes select z
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;

    // Vertex source codes for the emitted triangles
    localparam logic [2:0] SEL_V0 = 3'd0;
    localparam logic [2:0] SEL_V1 = 3'd1;
    localparam logic [2:0] SEL_V2 = 3'd2;
    localparam logic [2:0] SEL_C1 = 3'd3;
    localparam logic [2:0] SEL_C2 = 3'd4;

    typedef logic [2:0][CW-1:0] t_vtx;

    // Triangle with its cut plan
    typedef struct packed {
        t_vtx [2:0]            v;        // input vertices
        logic [2:0][2:0][2:0]  sel;      // [piece][corner] vertex source
        logic [2:0]            side;     // side of each piece
        logic [1:0]            last_idx; // index of the final piece
        logic [1:0][1:0]       ea;       // edge start vertex per cut lane
        logic [1:0][1:0]       eb;       // edge end vertex per cut lane
        logic [1:0]            mid;      // near-parallel edge: take midpoint
        logic [1:0]            t0;       // parameter clamps to zero
        logic [1:0]            t1;       // parameter clamps to one
    } t_plan;

    // One divider lane: remainder, divisor, quotient so far
    typedef struct packed {
        logic [EW-1:0]     rem;
        logic [EW-1:0]     den;
        logic [T_FRAC-1:0] quo;
    } t_div_lane;

    function automatic logic [2:0] vsel_of(input logic [1:0] idx);
        logic [2:0] s;
        case (idx)
            2'd0:    s = SEL_V0;
            2'd1:    s = SEL_V1;
            default: s = SEL_V2;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### rtl/core/tps_tri_if.sv
// Input channel: one triangle of three Q16.16 vertices.
`default_nettype none

interface tps_tri_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] v0_x;
    logic signed [31:0] v0_y;
    logic signed [31:0] v0_z;
    logic signed [31:0] v1_x;
    logic signed [31:0] v1_y;
    logic signed [31:0] v1_z;
    logic signed [31:0] v2_x;
    logic signed [31:0] v2_y;
    logic signed [31:0] v2_z;

    modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                    input ready);
    modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/tps_piece_if.sv
// Output channel: one triangle piece with its side and end marker.
`default_nettype none

interface tps_piece_if;
    logic               valid;
    logic               ready;
    logic               side;
    logic               last_piece;
    logic signed [31:0] tri_a_x;
    logic signed [31:0] tri_a_y;
    logic signed [31:0] tri_a_z;
    logic signed [31:0] tri_b_x;
    logic signed [31:0] tri_b_y;
    logic signed [31:0] tri_b_z;
    logic signed [31:0] tri_c_x;
    logic signed [31:0] tri_c_y;
    logic signed [31:0] tri_c_z;

    modport source (output valid, side, last_piece, tri_a_x, tri_a_y, tri_a_z,
                    tri_b_x, tri_b_y, tri_b_z, tri_c_x, tri_c_y, tri_c_z,
                    input ready);
    modport sink (input valid, side, last_piece, tri_a_x, tri_a_y, tri_a_z,
                  tri_b_x, tri_b_y, tri_b_z, tri_c_x, tri_c_y, tri_c_z,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/tps_front.sv
// Front stages: plane distances, case classification and divider operand setup.
`default_nettype none

module tps_front
    import tps_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire t_vtx [2:0]           i_v,
    input  wire logic [1:0]           i_axis,
    input  wire logic [CW-1:0]        i_value,
    output logic                      o_valid,
    output t_plan                     o_plan,
    output t_div_lane [1:0]           o_lanes
);

    // Stage 1: distances along the split axis
    logic                  r1_valid;
    t_vtx [2:0]            r1_v;
    logic signed [DW-1:0]  r1_d [3];
    logic signed [DW-1:0]  n1_d [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            case (i_axis)
                AXIS_X:  n1_d[i] = DW'($signed(i_v[i][0])) - DW'($signed(i_value));
                AXIS_Y:  n1_d[i] = DW'($signed(i_v[i][1])) - DW'($signed(i_value));
                default: n1_d[i] = DW'($signed(i_v[i][2])) - DW'($signed(i_value));
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
        if (i_en) begin
            r1_v <= i_v;
            for (int i = 0; i < 3; i++) r1_d[i] <= n1_d[i];
        end
    end

    // Stage 2: pick the case, the pieces and the edges to cut
    logic                  r2_valid;
    t_plan                 r2_plan;
    logic signed [DW-1:0]  r2_num [2];
    logic signed [EW-1:0]  r2_den [2];
    t_plan                 n2_plan;
    logic signed [DW-1:0]  n2_num [2];
    logic signed [EW-1:0]  n2_den [2];
    logic [2:0]            neg;
    logic [2:0]            pos;
    logic [2:0]            on_pl;
    logic                  f;
    logic [1:0]            l_i;
    logic [1:0]            p_i;
    logic [1:0]            q_i;
    logic signed [DW-1:0]  da;
    logic signed [DW-1:0]  db;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            neg[i]   = r1_d[i][DW-1];
            pos[i]   = !r1_d[i][DW-1] && (|r1_d[i]);
            on_pl[i] = (r1_d[i] > -EPS_Q) && (r1_d[i] < EPS_Q);
        end
        n2_plan          = '0;
        n2_plan.v        = r1_v;
        n2_plan.sel[0]   = {SEL_V2, SEL_V1, SEL_V0};
        n2_plan.side[0]  = !(|neg);
        n2_plan.last_idx = 2'd0;
        n2_plan.ea       = '0;
        n2_plan.eb       = '0;
        f   = 1'b0;
        l_i = 2'd2;
        p_i = 2'd0;
        q_i = 2'd1;
        if ((|neg) && !(&neg)) begin
            if (on_pl[0]) begin
                n2_plan.ea[0]  = 2'd1;
                n2_plan.eb[0]  = 2'd2;
                f              = pos[1];
                n2_plan.sel[0] = {SEL_C1, SEL_V1, SEL_V0};
                n2_plan.sel[1] = {SEL_V2, SEL_C1, SEL_V0};
                n2_plan.side[0] = f;
                n2_plan.side[1] = !f;
                n2_plan.last_idx = 2'd1;
            end else if (on_pl[1]) begin
                n2_plan.ea[0]  = 2'd0;
                n2_plan.eb[0]  = 2'd2;
                f              = pos[0];
                n2_plan.sel[0] = {SEL_C1, SEL_V1, SEL_V0};
                n2_plan.sel[1] = {SEL_C1, SEL_V2, SEL_V1};
                n2_plan.side[0] = f;
                n2_plan.side[1] = !f;
                n2_plan.last_idx = 2'd1;
            end else if (on_pl[2]) begin
                n2_plan.ea[0]  = 2'd0;
                n2_plan.eb[0]  = 2'd1;
                f              = pos[0];
                n2_plan.sel[0] = {SEL_V2, SEL_C1, SEL_V0};
                n2_plan.sel[1] = {SEL_V2, SEL_V1, SEL_C1};
                n2_plan.side[0] = f;
                n2_plan.side[1] = !f;
                n2_plan.last_idx = 2'd1;
            end else begin
                // Lone vertex: two pieces on the pair's side, one on its own
                if (pos[0] == pos[1]) begin
                    l_i = 2'd2;
                end else if (pos[0] == pos[2]) begin
                    l_i = 2'd1;
                end else begin
                    l_i = 2'd0;
                end
                p_i = (l_i == 2'd2) ? 2'd0 : (l_i + 2'd1);
                q_i = (p_i == 2'd2) ? 2'd0 : (p_i + 2'd1);
                f   = pos[l_i];
                n2_plan.ea[0]  = l_i;
                n2_plan.eb[0]  = p_i;
                n2_plan.ea[1]  = l_i;
                n2_plan.eb[1]  = q_i;
                n2_plan.sel[0] = {SEL_C2, vsel_of(q_i), vsel_of(p_i)};
                n2_plan.sel[1] = {SEL_C1, SEL_C2, vsel_of(p_i)};
                n2_plan.sel[2] = {vsel_of(l_i), SEL_C2, SEL_C1};
                n2_plan.side   = {f, !f, !f};
                n2_plan.last_idx = 2'd2;
            end
        end
        for (int k = 0; k < 2; k++) begin
            da = r1_d[n2_plan.ea[k]];
            db = r1_d[n2_plan.eb[k]];
            n2_num[k] = da;
            n2_den[k] = EW'(da) - EW'(db);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r2_plan <= n2_plan;
            for (int k = 0; k < 2; k++) begin
                r2_num[k] <= n2_num[k];
                r2_den[k] <= n2_den[k];
            end
        end
    end

    // Stage 3: make the divisor positive and flag the clamped and parallel cases
    logic                  r3_valid;
    t_plan                 r3_plan;
    t_div_lane [1:0]       r3_lanes;
    t_plan                 n3_plan;
    t_div_lane [1:0]       n3_lanes;
    logic signed [EW-1:0]  num_e;

    always_comb begin
        n3_plan  = r2_plan;
        n3_lanes = '0;
        for (int k = 0; k < 2; k++) begin
            num_e = EW'(r2_num[k]);
            n3_plan.mid[k] = (r2_den[k] > -EPS_Q) && (r2_den[k] < EPS_Q);
            if (r2_den[k][EW-1]) begin
                n3_plan.t0[k]    = !num_e[EW-1];
                n3_plan.t1[k]    = (num_e <= r2_den[k]);
                n3_lanes[k].rem  = -num_e;
                n3_lanes[k].den  = -r2_den[k];
            end else begin
                n3_plan.t0[k]    = (num_e <= 0);
                n3_plan.t1[k]    = (num_e >= r2_den[k]);
                n3_lanes[k].rem  = num_e;
                n3_lanes[k].den  = r2_den[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
        if (i_en) begin
            r3_plan  <= n3_plan;
            r3_lanes <= n3_lanes;
        end
    end

    assign o_valid = r3_valid;
    assign o_plan  = r3_plan;
    assign o_lanes = r3_lanes;

endmodule

`default_nettype wire

### rtl/core/tps_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes.
`default_nettype none

module tps_div_pipe
    import tps_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire t_plan            i_plan,
    input  wire t_div_lane [1:0]  i_lanes,
    output logic                  o_valid,
    output t_plan                 o_plan,
    output t_div_lane [1:0]       o_lanes
);

    function automatic t_div_lane div_step(input t_div_lane a);
        t_div_lane     r;
        logic [EW-1:0] sh;
        r  = a;
        sh = {a.rem[EW-2:0], 1'b0};
        if (sh >= a.den) begin
            r.rem = sh - a.den;
            r.quo = {a.quo[T_FRAC-2:0], 1'b1};
        end else begin
            r.rem = sh;
            r.quo = {a.quo[T_FRAC-2:0], 1'b0};
        end
        return r;
    endfunction

    logic             r_valid [DIV_STAGES];
    t_plan            r_plan  [DIV_STAGES];
    t_div_lane [1:0]  r_lanes [DIV_STAGES];

    // Advance each stage by one quotient bit
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic             in_valid;
        t_plan            in_plan;
        t_div_lane [1:0]  in_lanes;

        if (s == 0) begin : g_first
            assign in_valid = i_valid;
            assign in_plan  = i_plan;
            assign in_lanes = i_lanes;
        end else begin : g_next
            assign in_valid = r_valid[s-1];
            assign in_plan  = r_plan[s-1];
            assign in_lanes = r_lanes[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= in_valid;
            end
            if (i_en) begin
                r_plan[s]     <= in_plan;
                r_lanes[s][0] <= div_step(in_lanes[0]);
                r_lanes[s][1] <= div_step(in_lanes[1]);
            end
        end
    end

    assign o_valid = r_valid[DIV_STAGES-1];
    assign o_plan  = r_plan[DIV_STAGES-1];
    assign o_lanes = r_lanes[DIV_STAGES-1];

endmodule

`default_nettype wire

### rtl/core/tps_lerp.sv
// Edge interpolation: parameter select, split products, round and offset.
`default_nettype none

module tps_lerp
    import tps_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire t_plan            i_plan,
    input  wire t_div_lane [1:0]  i_lanes,
    output logic                  o_valid,
    output t_plan                 o_plan,
    output t_vtx [1:0]            o_cut
);

    localparam logic [TW-1:0]        T_ONE  = TW'(1) << T_FRAC;
    localparam logic signed [PW-1:0] T_HALF = PW'(1) <<< (T_FRAC - 1);

    // Stage 1: parameter, edge direction and midpoint
    logic                  r1_valid;
    t_plan                 r1_plan;
    logic [TW-1:0]         r1_t    [2];
    logic signed [DW-1:0]  r1_diff [2][3];
    logic [CW-1:0]         r1_a    [2][3];
    logic [CW-1:0]         r1_midv [2][3];
    logic [TW-1:0]         n1_t    [2];
    logic signed [DW-1:0]  n1_diff [2][3];
    logic [CW-1:0]         n1_a    [2][3];
    logic [CW-1:0]         n1_midv [2][3];
    logic signed [DW-1:0]  sum;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            if (i_plan.t0[k]) begin
                n1_t[k] = '0;
            end else if (i_plan.t1[k]) begin
                n1_t[k] = T_ONE;
            end else begin
                n1_t[k] = {1'b0, i_lanes[k].quo};
            end
            for (int c = 0; c < 3; c++) begin
                n1_a[k][c]    = i_plan.v[i_plan.ea[k]][c];
                n1_diff[k][c] = DW'($signed(i_plan.v[i_plan.eb[k]][c]))
                              - DW'($signed(i_plan.v[i_plan.ea[k]][c]));
                sum           = DW'($signed(i_plan.v[i_plan.eb[k]][c]))
                              + DW'($signed(i_plan.v[i_plan.ea[k]][c]));
                n1_midv[k][c] = sum[DW-1:1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
        if (i_en) begin
            r1_plan <= i_plan;
            r1_t    <= n1_t;
            r1_diff <= n1_diff;
            r1_a    <= n1_a;
            r1_midv <= n1_midv;
        end
    end

    // Stage 2: two partial products per coordinate
    logic                          r2_valid;
    t_plan                         r2_plan;
    logic signed [DW+T_HI_W:0]     r2_phi  [2][3];
    logic signed [DW+T_LO_W:0]     r2_plo  [2][3];
    logic [CW-1:0]                 r2_a    [2][3];
    logic [CW-1:0]                 r2_midv [2][3];
    logic signed [DW+T_HI_W:0]     n2_phi  [2][3];
    logic signed [DW+T_LO_W:0]     n2_plo  [2][3];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            for (int c = 0; c < 3; c++) begin
                n2_phi[k][c] = r1_diff[k][c] * $signed({1'b0, r1_t[k][TW-1:T_LO_W]});
                n2_plo[k][c] = r1_diff[k][c] * $signed({1'b0, r1_t[k][T_LO_W-1:0]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r2_plan <= r1_plan;
            r2_phi  <= n2_phi;
            r2_plo  <= n2_plo;
            r2_a    <= r1_a;
            r2_midv <= r1_midv;
        end
    end

    // Stage 3: combine, round, offset from the start vertex, or take the midpoint
    logic                  r3_valid;
    t_plan                 r3_plan;
    t_vtx [1:0]            r3_cut;
    t_vtx [1:0]            n3_cut;
    logic signed [PW-1:0]  off;
    logic signed [PW-1:0]  step;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            for (int c = 0; c < 3; c++) begin
                off  = (PW'(r2_phi[k][c]) <<< T_LO_W) + PW'(r2_plo[k][c]) + T_HALF;
                step = off >>> T_FRAC;
                if (r2_plan.mid[k]) begin
                    n3_cut[k][c] = r2_midv[k][c];
                end else begin
                    n3_cut[k][c] = r2_a[k][c] + step[CW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
        if (i_en) begin
            r3_plan <= r2_plan;
            r3_cut  <= n3_cut;
        end
    end

    assign o_valid = r3_valid;
    assign o_plan  = r3_plan;
    assign o_cut   = r3_cut;

endmodule

`default_nettype wire

### rtl/core/tps_emit.sv
// Piece sequencer: holds one cut triangle and sends its pieces one per transfer.
`default_nettype none

module tps_emit
    import tps_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_plan    i_plan,
    input  wire t_vtx [1:0] i_cut,
    output logic          o_take,
    tps_piece_if.source   o_piece
);

    function automatic logic [2:0][CW-1:0] pick(input t_plan p, input t_vtx [1:0] cut,
                                                input logic [2:0] code);
        logic [2:0][CW-1:0] r;
        case (code)
            SEL_V0:  r = p.v[0];
            SEL_V1:  r = p.v[1];
            SEL_V2:  r = p.v[2];
            SEL_C1:  r = cut[0];
            SEL_C2:  r = cut[1];
            default: r = p.v[0];
        endcase
        return r;
    endfunction

    logic         r_hold_v;
    t_plan        r_hold;
    t_vtx [1:0]   r_hold_cut;
    logic [1:0]   r_idx;
    logic         r_out_v;
    logic         r_out_side;
    logic         r_out_last;
    t_vtx [2:0]   r_out_tri;

    logic         out_free;
    logic         issue;
    logic         last;

    // Issue a piece whenever the output register is free or being drained
    assign out_free = !r_out_v || o_piece.ready;
    assign issue    = r_hold_v && out_free;
    assign last     = (r_idx == r_hold.last_idx);
    assign o_take   = !r_hold_v || (issue && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_idx    <= 2'd0;
            r_out_v  <= 1'b0;
        end else begin
            if (o_take) begin
                r_hold_v <= i_valid;
                r_idx    <= 2'd0;
            end else if (issue) begin
                r_idx <= r_idx + 2'd1;
            end
            if (issue) begin
                r_out_v <= 1'b1;
            end else if (o_piece.ready) begin
                r_out_v <= 1'b0;
            end
        end
        if (o_take) begin
            r_hold     <= i_plan;
            r_hold_cut <= i_cut;
        end
        if (issue) begin
            r_out_side <= r_hold.side[r_idx];
            r_out_last <= last;
            for (int j = 0; j < 3; j++) begin
                r_out_tri[j] <= pick(r_hold, r_hold_cut, r_hold.sel[r_idx][j]);
            end
        end
    end

    assign o_piece.valid      = r_out_v;
    assign o_piece.side       = r_out_side;
    assign o_piece.last_piece = r_out_last;
    assign o_piece.tri_a_x    = OW'($signed(r_out_tri[0][0]));
    assign o_piece.tri_a_y    = OW'($signed(r_out_tri[0][1]));
    assign o_piece.tri_a_z    = OW'($signed(r_out_tri[0][2]));
    assign o_piece.tri_b_x    = OW'($signed(r_out_tri[1][0]));
    assign o_piece.tri_b_y    = OW'($signed(r_out_tri[1][1]));
    assign o_piece.tri_b_z    = OW'($signed(r_out_tri[1][2]));
    assign o_piece.tri_c_x    = OW'($signed(r_out_tri[2][0]));
    assign o_piece.tri_c_y    = OW'($signed(r_out_tri[2][1]));
    assign o_piece.tri_c_z    = OW'($signed(r_out_tri[2][2]));

    // The piece index never runs past the held triangle's final piece
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_v |-> (r_idx <= r_hold.last_idx))
        else $error("piece index beyond last piece");

    // A held triangle never has more than three pieces
    a_count_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_v |-> (r_hold.last_idx != 2'd3))
        else $error("piece count out of range");

    // A new triangle is taken over a busy hold only while its last piece leaves
    a_take_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && r_hold_v) |-> (issue && last))
        else $error("held triangle dropped early");

    // An issued final piece shows up marked as last
    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && last) |=> (r_out_v && r_out_last))
        else $error("final piece not marked");

endmodule

`default_nettype wire

### rtl/core/triangle_plane_split_unit.sv
// Top level: cuts each input triangle by a configured axis-aligned plane.
//
// Usage:
//  - i_tri takes one triangle per transfer (valid/ready); o_piece returns 1 to 3
//    triangles per input, in order, the final one marked by last_piece.
//  - Configuration: i_cfg_we with i_cfg_idx 0 writes the split axis, index 1 the
//    signed Q16.16 plane position. Write only while the unit is idle.
//  - Path: the first piece of a triangle passes 3 setup stages, 30 divider stages,
//    3 interpolation stages, the hold register and the output register.
//  - Throughput: one input per cycle while each input gives one piece and o_piece
//    is ready; an input that gives more pieces holds the input and the pipeline
//    until its final piece is issued, as o_piece takes one piece per transfer.
//  - Stall: when o_piece is not ready while a triangle is held, the whole pipeline
//    holds in place and i_tri.ready drops; nothing is lost or repeated.
//  - Reset (synchronous, active low) empties the pipeline and sets the axis to x
//    and the plane position to zero.
`default_nettype none

module triangle_plane_split_unit
    import tps_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    tps_tri_if.sink                    i_tri,
    tps_piece_if.source                o_piece,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [31:0]           i_cfg_data
);

    logic [1:0]     r_axis;
    logic [CW-1:0]  r_value;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis  <= 2'd0;
            r_value <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SPLIT_AXIS:  r_axis  <= i_cfg_data[1:0];
                REG_SPLIT_VALUE: r_value <= i_cfg_data[CW-1:0];
                default:         ;
            endcase
        end
    end

    logic             en;
    t_vtx [2:0]       in_v;
    logic             f_valid;
    t_plan            f_plan;
    t_div_lane [1:0]  f_lanes;
    logic             d_valid;
    t_plan            d_plan;
    t_div_lane [1:0]  d_lanes;
    logic             l_valid;
    t_plan            l_plan;
    t_vtx [1:0]       l_cut;

    assign i_tri.ready = en;
    assign in_v[0] = {i_tri.v0_z[CW-1:0], i_tri.v0_y[CW-1:0], i_tri.v0_x[CW-1:0]};
    assign in_v[1] = {i_tri.v1_z[CW-1:0], i_tri.v1_y[CW-1:0], i_tri.v1_x[CW-1:0]};
    assign in_v[2] = {i_tri.v2_z[CW-1:0], i_tri.v2_y[CW-1:0], i_tri.v2_x[CW-1:0]};

    tps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_tri.valid),
        .i_v     (in_v),
        .i_axis  (r_axis),
        .i_value (r_value),
        .o_valid (f_valid),
        .o_plan  (f_plan),
        .o_lanes (f_lanes)
    );

    tps_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_plan  (f_plan),
        .i_lanes (f_lanes),
        .o_valid (d_valid),
        .o_plan  (d_plan),
        .o_lanes (d_lanes)
    );

    tps_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d_valid),
        .i_plan  (d_plan),
        .i_lanes (d_lanes),
        .o_valid (l_valid),
        .o_plan  (l_plan),
        .o_cut   (l_cut)
    );

    tps_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (l_valid),
        .i_plan  (l_plan),
        .i_cut   (l_cut),
        .o_take  (en),
        .o_piece (o_piece)
    );

endmodule

`default_nettype wire
